### sv/bsm_pkg.sv
package bsm_pkg;

  // Default coordinate width (signed Q16.16 centers)
  localparam int COORD_WIDTH_DEF = 32;

  // Round a bit count up to whole bytes
  function automatic int pad_bytes(input int n);
    return ((n + 7) >> 3) << 3;
  endfunction

endpackage

### sv/bsm_sqrt_pipe.sv
module bsm_sqrt_pipe
  import bsm_pkg::*;
#(
  parameter int IN_W   = 68,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       in_val,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [IN_W/2-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int N   = IN_W / 2;
  localparam int RMW = N + 2;

  logic [IN_W-1:0]   x    [0:N];
  logic [RMW-1:0]    rem  [0:N];
  logic [N-1:0]      root [0:N];
  logic [SIDE_W-1:0] side [0:N];
  logic [N:0]        vld;

  assign x[0]    = in_val;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  // One result bit per stage, two radicand bits consumed each step
  for (genvar i = 0; i < N; i++) begin : g_step
    logic [N+3:0] remt;
    logic [N+3:0] trial;
    logic         ge;
    logic [N+3:0] diff;

    always_comb begin
      remt  = {rem[i], x[i][IN_W-1 -: 2]};
      trial = {2'b00, root[i], 2'b01};
      ge    = remt >= trial;
      diff  = remt - trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x[i+1]    <= {x[i][IN_W-3:0], 2'b00};
        rem[i+1]  <= ge ? diff[RMW-1:0] : remt[RMW-1:0];
        root[i+1] <= {root[i][N-2:0], ge};
        side[i+1] <= side[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_side  = side[N];

endmodule

### sv/bsm_div_pipe.sv
module bsm_div_pipe
  import bsm_pkg::*;
#(
  parameter int NUM_W  = 67,
  parameter int DEN_W  = 34,
  parameter int QW     = 33,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [NUM_W-1:0]      in_num [0:2],
  input  logic [DEN_W-1:0]      in_den,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [QW-1:0]         out_quo [0:2],
  output logic [SIDE_W-1:0]     out_side
);

  // Partial remainder stays below the divisor (quotient known to fit QW bits)
  localparam int RW = NUM_W - QW;

  logic [RW-1:0]     rem  [0:QW][0:2];
  logic [QW-1:0]     lq   [0:QW][0:2];
  logic [DEN_W-1:0]  den  [0:QW];
  logic [SIDE_W-1:0] side [0:QW];
  logic [QW:0]       vld;

  for (genvar l = 0; l < 3; l++) begin : g_in
    assign rem[0][l] = in_num[l][NUM_W-1:QW];
    assign lq[0][l]  = in_num[l][QW-1:0];
  end
  assign den[0]  = in_den;
  assign side[0] = in_side;
  assign vld[0]  = in_valid;

  // Restoring division, one quotient bit per stage per lane
  for (genvar i = 0; i < QW; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den[i+1]  <= den[i];
        side[i+1] <= side[i];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [RW:0] t;
      logic [RW:0] dx;
      logic        ge;

      always_comb begin
        t  = {rem[i][l], lq[i][l][QW-1]};
        dx = (RW + 1)'(den[i]);
        ge = t >= dx;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1][l] <= ge ? RW'(t - dx) : t[RW-1:0];
          lq[i+1][l]  <= {lq[i][l][QW-2:0], ge};
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_quo[l] = lq[QW][l];
  end
  assign out_valid = vld[QW];
  assign out_side  = side[QW];

endmodule

### sv/bounding_sphere_merge_top.sv
// Bounding sphere merge, 3D, signed fixed point.
// Input channel s_axis_*: one beat carries two spheres (center x/y/z and
// radius each). Output channel m_axis_*: one beat carries the smallest
// enclosing sphere, the growth of the squared radius over the first sphere,
// a strict overlap flag and a saturation flag.
// The pipeline has three front stages (offsets, squares, distance), CW+2
// square root stages (one root bit each), radius and product stages, CW+1
// divider stages (one quotient bit each) and the output register. It takes
// one beat per cycle while the output register is not stalled.
// All stages move together: the pipeline advances whenever the output
// register is empty or being taken, so s_axis_tready follows m_axis_tready
// while a result is held. A stall loses and repeats nothing.
// Reset (rst, synchronous) clears every stage valid bit; there is no other
// state and no clearing pass.
module bounding_sphere_merge_top
  import bsm_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // first_x, first_y, first_z, first_rad, second_x, second_y, second_z,
  // second_rad, zero fill
  input  logic [pad_bytes(8*CW-2)-1:0]        s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // merged_x, merged_y, merged_z, merged_rad, growth, overlap, saturated,
  // zero fill
  output logic [pad_bytes(6*CW-1)-1:0]        m_axis_tdata
);

  localparam int RW    = CW - 1;
  localparam int MW    = CW + 1;
  localparam int SQW   = 2 * MW;
  localparam int DW    = 2 * CW + 4;
  localparam int RTW   = DW / 2;
  localparam int PW    = MW + RTW;
  localparam int QW    = CW + 1;
  localparam int IN_TW = pad_bytes(8*CW-2);
  localparam int OT_W  = pad_bytes(6*CW-1);
  localparam logic [RW-1:0] RMAX = '1;

  typedef logic signed [CW-1:0] crd_t;

  typedef struct packed {
    crd_t [2:0]          f;
    logic [2:0]          sgn;
    logic [2:0][MW-1:0]  mag;
    crd_t [2:0]          c_enc;
    logic [RW-1:0]       rad_enc;
    logic [RW-1:0]       r1;
    logic [RW-1:0]       r2;
    logic                enclose;
    logic                overlap;
  } sq_side_t;

  typedef struct packed {
    crd_t [2:0]          f;
    logic [2:0]          sgn;
    crd_t [2:0]          c_enc;
    logic [RW-1:0]       rad;
    logic [2*RW-1:0]     radsq;
    logic [2*RW-1:0]     r1sq;
    logic                enclose;
    logic                overlap;
    logic                sat;
  } dv_side_t;

  logic en;

  // Whole pipeline advances when the output register can take a beat
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // ---------------- stage A: offsets, magnitudes, enclose candidates
  crd_t          in_f [0:2];
  crd_t          in_s [0:2];
  logic [RW-1:0] in_r1, in_r2;

  for (genvar i = 0; i < 3; i++) begin : g_unpack
    assign in_f[i] = s_axis_tdata[i*CW +: CW];
    assign in_s[i] = s_axis_tdata[4*CW-1 + i*CW +: CW];
  end
  assign in_r1 = s_axis_tdata[3*CW +: RW];
  assign in_r2 = s_axis_tdata[7*CW-1 +: RW];

  logic               a_vld;
  crd_t [2:0]         a_f;
  logic [2:0]         a_sgn;
  logic [2:0][MW-1:0] a_mag;
  crd_t [2:0]         a_cenc;
  logic [RW-1:0]      a_r1, a_r2, a_rd, a_radenc;
  logic [CW-1:0]      a_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW:0] off;
    logic               tf;
    if (en) begin
      tf = in_r1 > in_r2;
      for (int i = 0; i < 3; i++) begin
        off       = $signed({in_s[i][CW-1], in_s[i]}) - $signed({in_f[i][CW-1], in_f[i]});
        a_f[i]    <= in_f[i];
        a_sgn[i]  <= off[CW];
        a_mag[i]  <= off[CW] ? MW'(-off) : MW'(off);
        a_cenc[i] <= tf ? in_f[i] : in_s[i];
      end
      a_r1     <= in_r1;
      a_r2     <= in_r2;
      a_rd     <= (in_r2 >= in_r1) ? in_r2 - in_r1 : in_r1 - in_r2;
      a_sum    <= CW'(in_r1) + CW'(in_r2);
      a_radenc <= tf ? in_r1 : in_r2;
    end
  end

  // ---------------- stage B: squares
  logic                b_vld;
  logic [2:0][SQW-1:0] b_msq;
  logic [2*RW-1:0]     b_rd2;
  logic [2*CW-1:0]     b_s2;
  crd_t [2:0]          b_f, b_cenc;
  logic [2:0]          b_sgn;
  logic [2:0][MW-1:0]  b_mag;
  logic [RW-1:0]       b_r1, b_r2, b_radenc;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (en) begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_msq[i] <= SQW'(a_mag[i]) * SQW'(a_mag[i]);
      end
      b_rd2    <= (2*RW)'(a_rd) * (2*RW)'(a_rd);
      b_s2     <= (2*CW)'(a_sum) * (2*CW)'(a_sum);
      b_f      <= a_f;
      b_cenc   <= a_cenc;
      b_sgn    <= a_sgn;
      b_mag    <= a_mag;
      b_r1     <= a_r1;
      b_r2     <= a_r2;
      b_radenc <= a_radenc;
    end
  end

  // ---------------- stage C: distance squared, branch and overlap
  logic          c_vld;
  logic [DW-1:0] c_dist;
  sq_side_t      c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (en) begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] d;
    if (en) begin
      d = DW'(b_msq[0]) + DW'(b_msq[1]) + DW'(b_msq[2]);
      c_dist         <= d;
      c_side.f       <= b_f;
      c_side.sgn     <= b_sgn;
      c_side.mag     <= b_mag;
      c_side.c_enc   <= b_cenc;
      c_side.rad_enc <= b_radenc;
      c_side.r1      <= b_r1;
      c_side.r2      <= b_r2;
      c_side.enclose <= DW'(b_rd2) >= d;
      c_side.overlap <= d < DW'(b_s2);
    end
  end

  // ---------------- square root of distance squared
  logic           q_vld;
  logic [RTW-1:0] q_root;
  sq_side_t       q_side;

  bsm_sqrt_pipe #(
    .IN_W   (DW),
    .SIDE_W ($bits(sq_side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (c_vld),
    .in_val    (c_dist),
    .in_side   (c_side),
    .out_valid (q_vld),
    .out_root  (q_root),
    .out_side  (q_side)
  );

  // ---------------- stage D: half sum, shift scale, radius clamp
  logic               d_vld;
  logic [RTW-1:0]     d_k, d_dlen;
  logic [RW-1:0]      d_rad;
  logic               d_sat;
  sq_side_t           d_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else if (en) begin
      d_vld <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    logic [RTW:0]   tot;
    logic [RTW-1:0] full;
    logic           big;
    if (en) begin
      tot  = (RTW+1)'(q_root) + (RTW+1)'(q_side.r1) + (RTW+1)'(q_side.r2);
      full = tot[RTW:1];
      big  = full > RTW'(RMAX);
      d_k    <= (full >= RTW'(q_side.r1)) ? full - RTW'(q_side.r1) : '0;
      d_dlen <= q_root;
      d_rad  <= q_side.enclose ? q_side.rad_enc : (big ? RMAX : full[RW-1:0]);
      d_sat  <= !q_side.enclose && big;
      d_side <= q_side;
    end
  end

  // ---------------- stage E: shift products and radius squares
  logic           e_vld;
  logic [PW-1:0]  e_prod [0:2];
  logic [RTW-1:0] e_dlen;
  dv_side_t       e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else if (en) begin
      e_vld <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e_prod[i] <= PW'(d_side.mag[i]) * PW'(d_k);
      end
      // zero distance never takes the shift path; keep the divisor nonzero
      e_dlen         <= (d_dlen == '0) ? RTW'(1) : d_dlen;
      e_side.f       <= d_side.f;
      e_side.sgn     <= d_side.sgn;
      e_side.c_enc   <= d_side.c_enc;
      e_side.rad     <= d_rad;
      e_side.radsq   <= (2*RW)'(d_rad) * (2*RW)'(d_rad);
      e_side.r1sq    <= (2*RW)'(d_side.r1) * (2*RW)'(d_side.r1);
      e_side.enclose <= d_side.enclose;
      e_side.overlap <= d_side.overlap;
      e_side.sat     <= d_sat;
    end
  end

  // ---------------- center shift division
  logic          v_vld;
  logic [QW-1:0] v_quo [0:2];
  dv_side_t      v_side;

  bsm_div_pipe #(
    .NUM_W  (PW),
    .DEN_W  (RTW),
    .QW     (QW),
    .SIDE_W ($bits(dv_side_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (e_vld),
    .in_num    (e_prod),
    .in_den    (e_dlen),
    .in_side   (e_side),
    .out_valid (v_vld),
    .out_quo   (v_quo),
    .out_side  (v_side)
  );

  // ---------------- stage F: apply shift, clamp, output register
  crd_t [2:0]      o_c;
  logic [RW-1:0]   o_rad;
  logic [2*RW-1:0] o_growth;
  logic            o_overlap, o_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= v_vld;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [CW+2:0] shv, cs;
    logic                 hi, lo, clamp;
    if (en) begin
      clamp = 1'b0;
      for (int i = 0; i < 3; i++) begin
        shv = $signed({2'b00, v_quo[i]});
        if (v_side.sgn[i]) begin
          shv = -shv;
        end
        cs = $signed({{3{v_side.f[i][CW-1]}}, v_side.f[i]}) + shv;
        hi = cs > $signed((CW+3)'({1'b0, {(CW-1){1'b1}}}));
        lo = cs < -$signed((CW+3)'({1'b1, {(CW-1){1'b0}}}));
        if (v_side.enclose) begin
          o_c[i] <= v_side.c_enc[i];
        end else if (hi) begin
          o_c[i] <= {1'b0, {(CW-1){1'b1}}};
        end else if (lo) begin
          o_c[i] <= {1'b1, {(CW-1){1'b0}}};
        end else begin
          o_c[i] <= cs[CW-1:0];
        end
        clamp = clamp | (!v_side.enclose && (hi || lo));
      end
      o_rad     <= v_side.rad;
      o_growth  <= (v_side.radsq >= v_side.r1sq) ? v_side.radsq - v_side.r1sq : '0;
      o_overlap <= v_side.overlap;
      o_sat     <= v_side.sat | clamp;
    end
  end

  assign m_axis_tdata = OT_W'({o_sat, o_overlap, o_growth, o_rad, o_c[2], o_c[1], o_c[0]});

endmodule

### sv/bsm_checker.sv
module bsm_checker
  import bsm_pkg::*;
#(
  parameter int CW = COORD_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [pad_bytes(8*CW-2)-1:0] s_axis_tdata,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [pad_bytes(6*CW-1)-1:0] m_axis_tdata
);

  // A held result beat stays put until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat dropped or changed while stalled");

  // Input side is open exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // No result beat is shown right after reset is released
  a_no_spurious: assert property (@(posedge clk)
    rst ##1 !rst |-> !m_axis_tvalid)
    else $error("result beat appeared without an input beat");

  // An accepted input beat carries known data
  a_in_known: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
    else $error("input beat accepted with unknown data");

endmodule

bind bounding_sphere_merge_top bsm_checker #(.CW(CW)) u_bsm_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top
  import bsm_pkg::*;
;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int IN_W = pad_bytes(8*CW-2);
  localparam int OUT_W = pad_bytes(6*CW-1);
  localparam int LATENCY = 2*CW+9;
  localparam int N_RANDOM = 1930;
  localparam longint RAD_MAX = 64'h7FFF_FFFF;
  localparam longint C_MAX = 64'sh7FFF_FFFF;
  localparam longint C_MIN = -64'sh8000_0000;

  // one merged sphere result, fields as on m_axis_tdata
  typedef struct packed {
    logic        saturated;
    logic        overlap;
    logic [61:0] growth;
    logic [30:0] rad;
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } merge_res_t;

  // merge predictor plus expected-result store
  class sphere_scoreboard;
    merge_res_t exp_q[$];
    int mismatches;

    function merge_res_t merge_spheres(logic [IN_W-1:0] d);
      longint f[3], off[3], c[3];
      bit [63:0] mag[3];
      bit [63:0] r1, r2, rd, dlen, full, k, rad, sum, cand;
      bit [127:0] dsq, prod;
      bit sat;
      merge_res_t r;
      r1 = 64'(d[126:96]);
      r2 = 64'(d[253:223]);
      dsq = 0;
      sat = 0;
      for (int i = 0; i < 3; i++) begin
        f[i] = longint'($signed(d[32*i +: 32]));
        off[i] = longint'($signed(d[127 + 32*i +: 32])) - f[i];
        mag[i] = off[i] < 0 ? -off[i] : off[i];
        dsq += 128'(mag[i]) * 128'(mag[i]);
      end
      rd = r2 >= r1 ? r2 - r1 : r1 - r2;
      if (128'(rd * rd) >= dsq) begin
        // one sphere encloses the other; ties go to the second
        for (int i = 0; i < 3; i++) c[i] = r1 > r2 ? f[i] : f[i] + off[i];
        rad = r1 > r2 ? r1 : r2;
      end else begin
        dlen = 0;
        for (int b = 34; b >= 0; b--) begin
          cand = dlen | (64'd1 << b);
          if (128'(cand) * 128'(cand) <= dsq) dlen = cand;
        end
        full = (dlen + r1 + r2) >> 1;
        k = full >= r1 ? full - r1 : 0;
        rad = full;
        if (rad > RAD_MAX) begin
          rad = RAD_MAX;
          sat = 1;
        end
        for (int i = 0; i < 3; i++) begin
          c[i] = f[i];
          if (dlen != 0) begin
            prod = (128'(mag[i]) * 128'(k)) / 128'(dlen);
            c[i] += off[i] < 0 ? -longint'(prod[63:0]) : longint'(prod[63:0]);
          end
        end
      end
      // clamp centers to the coordinate range
      for (int i = 0; i < 3; i++) begin
        if (c[i] > C_MAX) begin
          c[i] = C_MAX;
          sat = 1;
        end
        if (c[i] < C_MIN) begin
          c[i] = C_MIN;
          sat = 1;
        end
      end
      sum = r1 + r2;
      r.x = c[0][31:0];
      r.y = c[1][31:0];
      r.z = c[2][31:0];
      r.rad = rad[30:0];
      r.growth = rad >= r1 ? 62'(rad * rad - r1 * r1) : 62'd0;
      r.overlap = dsq < 128'(sum) * 128'(sum);
      r.saturated = sat;
      return r;
    endfunction

    function void note_input(logic [IN_W-1:0] d);
      exp_q.push_back(merge_spheres(d));
    endfunction

    function void report(string what, logic [63:0] e, logic [63:0] a);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", what, e, a);
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      merge_res_t got, e;
      got = d[OUT_W-2:0];
      if (exp_q.size() == 0) begin
        report("unexpected beat", 64'd0, 64'd1);
        return;
      end
      e = exp_q.pop_front();
      if (got.x !== e.x) report("merged_x", e.x, got.x);
      if (got.y !== e.y) report("merged_y", e.y, got.y);
      if (got.z !== e.z) report("merged_z", e.z, got.z);
      if (got.rad !== e.rad) report("merged_rad", e.rad, got.rad);
      if (got.growth !== e.growth) report("growth", e.growth, got.growth);
      if (got.overlap !== e.overlap) report("overlap", e.overlap, got.overlap);
      if (got.saturated !== e.saturated) report("saturated", e.saturated, got.saturated);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;
  bit quiet = 0;
  sphere_scoreboard sb = new();

  always #10 clk = ~clk;

  bounding_sphere_merge_top #(.CW(CW)) u_top (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // receiver stalls about 6 percent of the time
  always @(posedge clk) begin
    m_axis_tready <= quiet || $urandom_range(99) >= 6;
  end

  // beat monitors
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  function automatic logic [IN_W-1:0] pack_pair(logic [31:0] fx, fy, fz, logic [30:0] fr,
                                               logic [31:0] sx, sy, sz, logic [30:0] sr);
    return {2'b00, sr, sz, sy, sx, fr, fz, fy, fx};
  endfunction

  function automatic logic [31:0] near(logic [31:0] base, int span);
    return base + $urandom_range(2*span) - span;
  endfunction

  // random pair shaped to hit each branch of the merge
  function automatic logic [IN_W-1:0] random_pair();
    logic [31:0] fx, fy, fz, sx, sy, sz;
    logic [30:0] fr, sr;
    int kind;
    kind = $urandom_range(9);
    fx = $urandom; fy = $urandom; fz = $urandom;
    fr = 31'($urandom); sr = 31'($urandom);
    sx = $urandom; sy = $urandom; sz = $urandom;
    case (kind)
      0, 1: ;
      2, 3, 4: begin
        // nearby spheres, partial overlap or apart
        fx = near(0, 1 << 22); fy = near(0, 1 << 22); fz = near(0, 1 << 22);
        sx = near(fx, 1 << 21); sy = near(fy, 1 << 21); sz = near(fz, 1 << 21);
        fr = 31'($urandom_range(1 << 21)); sr = 31'($urandom_range(1 << 21));
      end
      5, 6: begin
        // one sphere likely inside the other
        sx = near(fx, 1 << 12); sy = near(fy, 1 << 12); sz = near(fz, 1 << 12);
        fr = 31'($urandom_range(1 << 24));
        sr = $urandom_range(1) ? fr : 31'($urandom_range(1 << 24));
      end
      7: begin
        // common center
        sx = fx; sy = fy; sz = fz;
        if ($urandom_range(1)) sr = fr;
      end
      default: begin
        // large radii far apart: radius clamp
        fr = 31'(32'h7FFF_FFFF - $urandom_range(1 << 20));
        sr = 31'(32'h7FFF_FFFF - $urandom_range(1 << 20));
        fx = 32'h8000_0000 + $urandom_range(1 << 16);
        sx = 32'h7FFF_FFFF - $urandom_range(1 << 16);
      end
    endcase
    return pack_pair(fx, fy, fz, fr, sx, sy, sz, sr);
  endfunction

  task automatic send_pair(logic [IN_W-1:0] d);
    while (!quiet && $urandom_range(99) < 6) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed corners
    send_pair('0);
    send_pair(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF));
    send_pair(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'd0,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'd0));
    send_pair(pack_pair(32'h8000_0000, 0, 0, 31'h7FFF_FFFF,
                        32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF));
    // equal radii, same center: second wins
    send_pair(pack_pair(32'h0001_0000, 2, 3, 31'h0003_0000,
                        32'h0001_0000, 2, 3, 31'h0003_0000));
    // first encloses second, then second encloses first
    send_pair(pack_pair(0, 0, 0, 31'h000A_0000, 32'h0001_0000, 0, 0, 31'h0001_0000));
    send_pair(pack_pair(0, 0, 0, 31'h0001_0000, 32'hFFFF_0000, 0, 0, 31'h000A_0000));
    // touching internally, exactly at the enclosure boundary
    send_pair(pack_pair(0, 0, 0, 31'h0005_0000, 32'h0003_0000, 0, 0, 31'h0002_0000));
    // externally tangent (no strict overlap), disjoint, overlapping
    send_pair(pack_pair(0, 0, 0, 31'h0001_0000, 32'h0002_0000, 0, 0, 31'h0001_0000));
    send_pair(pack_pair(0, 0, 0, 31'h0001_0000, 32'h0000_0000, 32'h0010_0000,
                        32'hFFF0_0000, 31'h0002_0000));
    send_pair(pack_pair(32'hFFFF_8000, 32'h0000_4000, 0, 31'h0001_0000,
                        32'h0000_8000, 32'hFFFF_C000, 32'h0000_1000, 31'h0001_0000));
    // zero radii, distinct points
    send_pair(pack_pair(1, 1, 1, 31'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0));
    // radius overflow
    send_pair(pack_pair(32'h8000_0000, 0, 0, 31'h7FFF_0000,
                        32'h7FFF_0000, 0, 0, 31'h7FFF_0000));

    // sender holds off until the pipe is empty
    drain();

    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = n >= 400 && n < 700;
      send_pair(random_pair());
      if (n == 1000) drain();
    end
    quiet = 0;
    drain();
    repeat (LATENCY + 10) @(posedge clk);

    if (sb.mismatches == 0 && sb.exp_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
